[sv/dmpi_pkg.sv]
// Shared widths, register codes and reset values for the dual motor PI speed controller.
package dmpi_pkg;

  // Field widths
  localparam int SPEED_W = 16;                // target / measured speed
  localparam int DUTY_W  = 16;                // duty outputs
  localparam int GAIN_W  = 16;                // Q8.8 gains
  localparam int LIMIT_W = 20;                // integral limit register
  localparam int CFG_W   = 20;                // widest config register
  localparam int CFG_IDX_W = 2;

  // Derived datapath widths
  localparam int ERR_W  = SPEED_W + 1;        // target - measured
  localparam int SUM_W  = LIMIT_W + 1;        // clamped integral, signed
  localparam int ACC_W  = SUM_W + 1;          // sum + err before clamp
  localparam int PP_W   = GAIN_W + 1 + ERR_W; // kp * err
  localparam int PI_W   = GAIN_W + 1 + ACC_W; // ki * sum
  localparam int RAW_W  = PI_W;               // kp*err + ki*sum, no overflow
  localparam int FRAC_W = 8;                  // Q8.8 scaling
  localparam int MAG_W  = RAW_W - FRAC_W;

  // Drive magnitude above which the saturation duty is used
  localparam logic [DUTY_W-1:0] DRIVE_LIMIT = DUTY_W'(10000);

  // Number of motors
  localparam int LANES = 2;
  localparam int LEFT  = 0;
  localparam int RIGHT = 1;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_DUTY       = 2'd3;

  // Reset values
  localparam logic [GAIN_W-1:0]  KP_RESET    = GAIN_W'(15360);
  localparam logic [GAIN_W-1:0]  KI_RESET    = GAIN_W'(102);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);
  localparam logic [DUTY_W-1:0]  SAT_RESET   = DUTY_W'(10000);

  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [PP_W-1:0]  pp_t;
  typedef logic signed [PI_W-1:0]  pi_t;
  typedef logic [DUTY_W-1:0]       duty_t;

endpackage

[sv/dual_motor_pi_speed_control.sv]
// Top level: dual motor PI speed controller with integral clamp, three-stage pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  in       | in_valid / in_ready  | target_left/right, measured_left/right (s16)
//  out      | out_valid/out_ready  | left/right forward/reverse duty (u16)
//  cfg      | cfg_we (no wait)     | cfg_idx (2b), cfg_data (20b)
//
//  One request per cycle unless out stalls; a request then passes the va, vb and vc valids.
//  Stage A: error, integral accumulate and clamp (the per-tick feedback loop).
//  Stage B: the two gain multipliers per side. Stage C: sum, |x|>>8, saturate.
//  Each stage has its own valid bit, so bubbles close up while out is stalled.
//  rst (synchronous) clears valids and integral sums and loads config reset values.
module dual_motor_pi_speed_control (
  input  logic                                 clk,
  input  logic                                 rst,
  // input requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dmpi_pkg::SPEED_W-1:0]  target_left,
  input  logic signed [dmpi_pkg::SPEED_W-1:0]  target_right,
  input  logic signed [dmpi_pkg::SPEED_W-1:0]  measured_left,
  input  logic signed [dmpi_pkg::SPEED_W-1:0]  measured_right,
  // result requests
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dmpi_pkg::DUTY_W-1:0]          left_forward_duty,
  output logic [dmpi_pkg::DUTY_W-1:0]          left_reverse_duty,
  output logic [dmpi_pkg::DUTY_W-1:0]          right_forward_duty,
  output logic [dmpi_pkg::DUTY_W-1:0]          right_reverse_duty,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [dmpi_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [dmpi_pkg::CFG_W-1:0]           cfg_data
);

  localparam int LANES = dmpi_pkg::LANES;

  // Config registers
  logic [dmpi_pkg::GAIN_W-1:0]  kp_gain;
  logic [dmpi_pkg::GAIN_W-1:0]  ki_gain;
  logic [dmpi_pkg::LIMIT_W-1:0] integral_limit;
  logic [dmpi_pkg::DUTY_W-1:0]  sat_duty;

  // Integral state per side
  dmpi_pkg::sum_t integral [LANES];
  dmpi_pkg::sum_t integral_next [LANES];

  // Pipeline registers
  logic           va, vb, vc;
  dmpi_pkg::err_t err_a [LANES];
  dmpi_pkg::acc_t acc_a [LANES];
  dmpi_pkg::pp_t  pp_b  [LANES];
  dmpi_pkg::pi_t  pi_b  [LANES];
  dmpi_pkg::duty_t fwd_c [LANES];
  dmpi_pkg::duty_t rev_c [LANES];

  // Stage-local combinational values
  dmpi_pkg::err_t  err_in  [LANES];
  dmpi_pkg::acc_t  acc_in  [LANES];
  dmpi_pkg::pp_t   pp_a    [LANES];
  dmpi_pkg::pi_t   pi_a    [LANES];
  dmpi_pkg::duty_t fwd_b   [LANES];
  dmpi_pkg::duty_t rev_b   [LANES];

  logic signed [dmpi_pkg::SPEED_W-1:0] tgt  [LANES];
  logic signed [dmpi_pkg::SPEED_W-1:0] meas [LANES];

  logic rdy_a, rdy_b, rdy_c;
  logic in_acc;

  // Handshake: each stage frees up when it is empty or its successor moves
  assign rdy_c    = !vc || out_ready;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;
  assign in_acc   = in_valid && in_ready;

  assign tgt[dmpi_pkg::LEFT]   = target_left;
  assign tgt[dmpi_pkg::RIGHT]  = target_right;
  assign meas[dmpi_pkg::LEFT]  = measured_left;
  assign meas[dmpi_pkg::RIGHT] = measured_right;

  // Config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain        <= dmpi_pkg::KP_RESET;
      ki_gain        <= dmpi_pkg::KI_RESET;
      integral_limit <= dmpi_pkg::LIMIT_RESET;
      sat_duty       <= dmpi_pkg::SAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dmpi_pkg::REG_KP_GAIN:        kp_gain        <= cfg_data[dmpi_pkg::GAIN_W-1:0];
        dmpi_pkg::REG_KI_GAIN:        ki_gain        <= cfg_data[dmpi_pkg::GAIN_W-1:0];
        dmpi_pkg::REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[dmpi_pkg::LIMIT_W-1:0];
        dmpi_pkg::REG_SAT_DUTY:       sat_duty       <= cfg_data[dmpi_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage A logic: error, accumulate, clamp to +/- limit
  always_comb begin
    dmpi_pkg::acc_t lim;
    lim = $signed({2'b00, integral_limit});
    for (int i = 0; i < LANES; i++) begin
      err_in[i] = dmpi_pkg::ERR_W'(tgt[i]) - dmpi_pkg::ERR_W'(meas[i]);
      acc_in[i] = dmpi_pkg::ACC_W'(integral[i]) + dmpi_pkg::ACC_W'(err_in[i]);
      if (acc_in[i] > lim) begin
        integral_next[i] = lim[dmpi_pkg::SUM_W-1:0];
      end else if (acc_in[i] < -lim) begin
        integral_next[i] = dmpi_pkg::SUM_W'(-lim);
      end else begin
        integral_next[i] = acc_in[i][dmpi_pkg::SUM_W-1:0];
      end
    end
  end

  // Stage B logic: gain products (unclamped sum feeds the integral term)
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pp_a[i] = dmpi_pkg::PP_W'($signed({1'b0, kp_gain})) * dmpi_pkg::PP_W'(err_a[i]);
      pi_a[i] = dmpi_pkg::PI_W'($signed({1'b0, ki_gain})) * dmpi_pkg::PI_W'(acc_a[i]);
    end
  end

  // Stage C logic: add, magnitude >> 8 (toward zero), saturate, steer by sign
  always_comb begin
    dmpi_pkg::pi_t             raw;
    dmpi_pkg::pi_t             absv;
    logic [dmpi_pkg::MAG_W-1:0] mag;
    dmpi_pkg::duty_t           duty;
    logic                      neg;
    for (int i = 0; i < LANES; i++) begin
      raw  = dmpi_pkg::RAW_W'(pp_b[i]) + pi_b[i];
      neg  = raw[dmpi_pkg::RAW_W-1];
      absv = neg ? -raw : raw;
      mag  = absv[dmpi_pkg::RAW_W-1:dmpi_pkg::FRAC_W];
      if (mag > dmpi_pkg::MAG_W'(dmpi_pkg::DRIVE_LIMIT)) begin
        duty = sat_duty;
      end else begin
        duty = mag[dmpi_pkg::DUTY_W-1:0];
      end
      if (!neg && duty != '0) begin
        fwd_b[i] = duty;
        rev_b[i] = '0;
      end else begin
        fwd_b[i] = '0;
        rev_b[i] = duty;
      end
    end
  end

  // Valid bits and integral state
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        integral[i] <= '0;
      end
    end else begin
      if (rdy_a) va <= in_acc;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (in_acc) begin
        for (int i = 0; i < LANES; i++) begin
          integral[i] <= integral_next[i];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (in_acc) begin
        err_a[i] <= err_in[i];
        acc_a[i] <= acc_in[i];
      end
      if (va && rdy_b) begin
        pp_b[i] <= pp_a[i];
        pi_b[i] <= pi_a[i];
      end
      if (vb && rdy_c) begin
        fwd_c[i] <= fwd_b[i];
        rev_c[i] <= rev_b[i];
      end
    end
  end

  assign out_valid          = vc;
  assign left_forward_duty  = fwd_c[dmpi_pkg::LEFT];
  assign left_reverse_duty  = rev_c[dmpi_pkg::LEFT];
  assign right_forward_duty = fwd_c[dmpi_pkg::RIGHT];
  assign right_reverse_duty = rev_c[dmpi_pkg::RIGHT];

  // Stored sums stay inside the bound in force when they were written
  a_int_bound: assert property (@(posedge clk) disable iff (rst)
    in_acc |=>
      (integral[dmpi_pkg::LEFT]  <= $signed({1'b0, $past(integral_limit)})) &&
      (integral[dmpi_pkg::LEFT]  >= -$signed({1'b0, $past(integral_limit)})) &&
      (integral[dmpi_pkg::RIGHT] <= $signed({1'b0, $past(integral_limit)})) &&
      (integral[dmpi_pkg::RIGHT] >= -$signed({1'b0, $past(integral_limit)})))
    else $error("integral sum outside clamp bound");

  // Never drive both directions of one motor
  a_one_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_forward_duty == '0 || left_reverse_duty == '0) &&
                  (right_forward_duty == '0 || right_reverse_duty == '0))
    else $error("forward and reverse duty both nonzero");

  // A left duty above the drive limit can only be the saturation duty
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (left_forward_duty > dmpi_pkg::DRIVE_LIMIT ||
                  left_reverse_duty > dmpi_pkg::DRIVE_LIMIT) |->
      (left_forward_duty == sat_duty || left_reverse_duty == sat_duty))
    else $error("left duty above limit is not the saturation duty");

  // A free output stage always lets a new request in
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule
